@@ rtl/fbc_pkg.sv @@
// Package for the frustum box cull block: constants, payload types and queue entry type.
package fbc_pkg;

   localparam int MAT_W       = 32;
   localparam int FRAC_BITS   = 16;
   localparam int COORD_WIDTH = 32;
   // coordinates narrowed to COORD_WIDTH, at most the full field width
   localparam int CW          = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
   localparam int COEF_W      = MAT_W + 1;
   localparam int PROD_W      = COEF_W + CW;
   localparam int SUM_W       = PROD_W + 2;
   localparam int NUM_PLANES  = 6;
   localparam int MAT_DEPTH   = 16;

   // plane slots in a queue entry
   localparam int PL_LEFT   = 0;
   localparam int PL_RIGHT  = 1;
   localparam int PL_BOTTOM = 2;
   localparam int PL_TOP    = 3;
   localparam int PL_NEAR   = 4;
   localparam int PL_FAR    = 5;

   // item kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TEST = 1'b1;

   // queue depths, powers of two
   localparam int TQ_DEPTH  = 4;
   localparam int TQ_PTR_W  = $clog2(TQ_DEPTH);
   localparam int TQ_CNT_W  = $clog2(TQ_DEPTH + 1);
   localparam int RQ_DEPTH  = 4;
   localparam int RQ_PTR_W  = $clog2(RQ_DEPTH);
   localparam int RQ_CNT_W  = $clog2(RQ_DEPTH + 3);

   typedef struct packed {
      logic                    kind;
      logic [1:0]              row;
      logic [1:0]              col;
      logic signed [MAT_W-1:0] matrix_value;
      logic signed [31:0]      min_x;
      logic signed [31:0]      min_y;
      logic signed [31:0]      min_z;
      logic signed [31:0]      max_x;
      logic signed [31:0]      max_y;
      logic signed [31:0]      max_z;
   } req_type;

   typedef struct packed {
      logic visible;
      logic frustum_ok;
   } rsp_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] a;
      logic signed [COEF_W-1:0] b;
      logic signed [COEF_W-1:0] c;
      logic signed [COEF_W-1:0] d;
   } plane_type;

   typedef struct packed {
      plane_type [NUM_PLANES-1:0] plane;
      logic signed [CW-1:0]       min_x;
      logic signed [CW-1:0]       min_y;
      logic signed [CW-1:0]       min_z;
      logic signed [CW-1:0]       max_x;
      logic signed [CW-1:0]       max_y;
      logic signed [CW-1:0]       max_z;
      logic                       frustum_ok;
      logic                       box_ok;
   } task_type;

endpackage

@@ rtl/frustum_box_cull.sv @@
// Top level of the view-frustum box culling block.
// Throughput: one item per cycle while req_full is low, loads and box tests alike, set by the 18
// parallel multipliers. A box test passes the box queue, products and partial sums to the result
// queue; a matrix load takes effect for the next item and gives no result.
// Reset (synchronous): the matrix clears to zero and both queues empty; ready on the next cycle.
module frustum_box_cull (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  fbc_pkg::req_type req_payload,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output fbc_pkg::rsp_type rsp_payload
);
   import fbc_pkg::*;

   logic     task_push;
   task_type task_data;
   logic     q_full;
   logic     q_empty;
   logic     q_pop;
   task_type q_head;

   fbc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_payload (req_payload),
      .req_full    (req_full),
      .q_full      (q_full),
      .task_push   (task_push),
      .task_data   (task_data)
   );

   fbc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (task_push),
      .wr_data (task_data),
      .full    (q_full),
      .pop     (q_pop),
      .rd_data (q_head),
      .empty   (q_empty)
   );

   fbc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTH
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   a_load_no_task: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && req_payload.kind == KIND_LOAD) |-> !task_push)
      else $error("matrix load entered the box queue");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("back end popped an empty box queue");

   a_test_queued: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && req_payload.kind == KIND_TEST) |=> !q_empty)
      else $error("accepted box test missing from queue");
`endif

endmodule

@@ rtl/fbc_front.sv @@
// Front end: accepts items, holds the matrix, forms planes and classifies test boxes.
module fbc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  fbc_pkg::req_type  req_payload,
   output logic              req_full,
   input  logic              q_full,
   output logic              task_push,
   output fbc_pkg::task_type task_data
);
   import fbc_pkg::*;

   logic signed [MAT_W-1:0]  mat_ff [MAT_DEPTH];
   logic signed [COEF_W-1:0] m [4][4];
   logic                     accept;
   logic                     load_en;
   logic [3:0]               load_idx;
   plane_type                pl [NUM_PLANES];
   logic                     ok;

   assign req_full  = q_full;
   assign accept    = req_push && !q_full;
   assign load_en   = accept && (req_payload.kind == KIND_LOAD);
   assign task_push = accept && (req_payload.kind == KIND_TEST);
   assign load_idx  = {req_payload.row, req_payload.col};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAT_DEPTH; i++) begin
            mat_ff[i] <= '0;
         end
      end else if (load_en) begin
         mat_ff[load_idx] <= req_payload.matrix_value;
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int k = 0; k < 4; k++) begin
            m[r][k] = COEF_W'(mat_ff[r*4 + k]);
         end
      end
      pl[PL_LEFT]   = '{a: m[3][0] + m[0][0], b: m[3][1] + m[0][1],
                        c: m[3][2] + m[0][2], d: m[3][3] + m[0][3]};
      pl[PL_RIGHT]  = '{a: m[3][0] - m[0][0], b: m[3][1] - m[0][1],
                        c: m[3][2] - m[0][2], d: m[3][3] - m[0][3]};
      pl[PL_BOTTOM] = '{a: m[3][0] + m[1][0], b: m[3][1] + m[1][1],
                        c: m[3][2] + m[1][2], d: m[3][3] + m[1][3]};
      pl[PL_TOP]    = '{a: m[3][0] - m[1][0], b: m[3][1] - m[1][1],
                        c: m[3][2] - m[1][2], d: m[3][3] - m[1][3]};
      pl[PL_NEAR]   = '{a: m[2][0], b: m[2][1], c: m[2][2], d: m[2][3]};
      pl[PL_FAR]    = '{a: m[3][0] - m[2][0], b: m[3][1] - m[2][1],
                        c: m[3][2] - m[2][2], d: m[3][3] - m[2][3]};

      ok = 1'b1;
      for (int p = 0; p < NUM_PLANES; p++) begin
         if (pl[p].a == '0 && pl[p].b == '0 && pl[p].c == '0) begin
            ok = 1'b0;
         end
         task_data.plane[p] = pl[p];
      end

      task_data.min_x      = CW'(req_payload.min_x);
      task_data.min_y      = CW'(req_payload.min_y);
      task_data.min_z      = CW'(req_payload.min_z);
      task_data.max_x      = CW'(req_payload.max_x);
      task_data.max_y      = CW'(req_payload.max_y);
      task_data.max_z      = CW'(req_payload.max_z);
      task_data.frustum_ok = ok;
      task_data.box_ok     = !(task_data.min_x > task_data.max_x ||
                               task_data.min_y > task_data.max_y ||
                               task_data.min_z > task_data.max_z);
   end

endmodule

@@ rtl/fbc_queue.sv @@
// Short queue of classified test boxes between front and back.
module fbc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fbc_pkg::task_type wr_data,
   output logic              full,
   input  logic              pop,
   output fbc_pkg::task_type rd_data,
   output logic              empty
);
   import fbc_pkg::*;

   task_type             mem_ff [TQ_DEPTH];
   logic [TQ_PTR_W-1:0]  wr_ptr_ff;
   logic [TQ_PTR_W-1:0]  rd_ptr_ff;
   logic [TQ_CNT_W-1:0]  count_ff;
   logic [TQ_CNT_W-1:0]  count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full    = (count_ff == TQ_CNT_W'(TQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ rtl/fbc_back.sv @@
// Back end: plane distance pipeline per box and the result queue.
module fbc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  fbc_pkg::task_type q_head,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output fbc_pkg::rsp_type  rsp_payload
);
   import fbc_pkg::*;

   // stage 1: corner pick and products
   logic                     s1_vld_ff;
   logic                     s1_ok_ff;
   logic                     s1_box_ff;
   logic signed [PROD_W-1:0] prod_ff [NUM_PLANES][3];
   logic signed [PROD_W-1:0] prod_in [NUM_PLANES][3];
   logic signed [COEF_W-1:0] d_ff [NUM_PLANES];
   // stage 2: partial sums
   logic                     s2_vld_ff;
   logic                     s2_ok_ff;
   logic                     s2_box_ff;
   logic signed [SUM_W-1:0]  half0_ff [NUM_PLANES];
   logic signed [SUM_W-1:0]  half1_ff [NUM_PLANES];
   logic signed [SUM_W-1:0]  half0_in [NUM_PLANES];
   logic signed [SUM_W-1:0]  half1_in [NUM_PLANES];
   logic signed [SUM_W-1:0]  total [NUM_PLANES];
   logic                     any_neg;
   rsp_type                  result;
   // result queue
   rsp_type                  rq_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0]      rq_wr_ff;
   logic [RQ_PTR_W-1:0]      rq_rd_ff;
   logic [RQ_CNT_W-1:0]      rq_count_ff;
   logic [RQ_CNT_W-1:0]      rq_count_in;
   logic [RQ_CNT_W-1:0]      inflight;
   logic                     rq_push;
   logic                     rq_pop;

   function automatic logic signed [CW-1:0] pick(input logic signed [COEF_W-1:0] coef,
                                                 input logic signed [CW-1:0] lo,
                                                 input logic signed [CW-1:0] hi);
      return (coef < 0) ? lo : hi;
   endfunction

   // issue only when the result queue has room for everything in flight
   assign inflight = RQ_CNT_W'(s1_vld_ff) + RQ_CNT_W'(s2_vld_ff);
   assign q_pop    = !q_empty && ((rq_count_ff + inflight) < RQ_CNT_W'(RQ_DEPTH));

   always_comb begin
      for (int p = 0; p < NUM_PLANES; p++) begin
         prod_in[p][0] = PROD_W'(q_head.plane[p].a) *
                         PROD_W'(pick(q_head.plane[p].a, q_head.min_x, q_head.max_x));
         prod_in[p][1] = PROD_W'(q_head.plane[p].b) *
                         PROD_W'(pick(q_head.plane[p].b, q_head.min_y, q_head.max_y));
         prod_in[p][2] = PROD_W'(q_head.plane[p].c) *
                         PROD_W'(pick(q_head.plane[p].c, q_head.min_z, q_head.max_z));
      end
   end

   always_comb begin
      for (int p = 0; p < NUM_PLANES; p++) begin
         half0_in[p] = SUM_W'(prod_ff[p][0]) + SUM_W'(prod_ff[p][1]);
         // offset moves from Q16.16 to the Q32.32 scale of the products
         half1_in[p] = SUM_W'(prod_ff[p][2]) + (SUM_W'(d_ff[p]) <<< FRAC_BITS);
      end
   end

   always_comb begin
      any_neg = 1'b0;
      for (int p = 0; p < NUM_PLANES; p++) begin
         total[p] = half0_ff[p] + half1_ff[p];
         if (total[p][SUM_W-1]) begin
            any_neg = 1'b1;
         end
      end
      result.frustum_ok = s2_ok_ff;
      result.visible    = !(s2_ok_ff && s2_box_ff) || !any_neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= q_pop;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ok_ff  <= q_head.frustum_ok;
      s1_box_ff <= q_head.box_ok;
      s2_ok_ff  <= s1_ok_ff;
      s2_box_ff <= s1_box_ff;
      for (int p = 0; p < NUM_PLANES; p++) begin
         d_ff[p]     <= q_head.plane[p].d;
         half0_ff[p] <= half0_in[p];
         half1_ff[p] <= half1_in[p];
         for (int k = 0; k < 3; k++) begin
            prod_ff[p][k] <= prod_in[p][k];
         end
      end
   end

   assign rq_push     = s2_vld_ff;
   assign rq_pop      = rsp_pop && !rsp_empty;
   assign rsp_empty   = (rq_count_ff == '0);
   assign rsp_payload = rq_ff[rq_rd_ff];

   always_comb begin
      rq_count_in = rq_count_ff;
      if (rq_push && !rq_pop) begin
         rq_count_in = rq_count_ff + 1'b1;
      end else if (rq_pop && !rq_push) begin
         rq_count_in = rq_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff    <= '0;
         rq_rd_ff    <= '0;
         rq_count_ff <= '0;
      end else begin
         rq_count_ff <= rq_count_in;
         if (rq_push) begin
            rq_wr_ff <= rq_wr_ff + 1'b1;
         end
         if (rq_pop) begin
            rq_rd_ff <= rq_rd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rq_push) begin
         rq_ff[rq_wr_ff] <= result;
      end
   end

endmodule

@@ bench/tb_frustum_box_cull.sv @@
// Self-checking testbench for frustum_box_cull: matrix loads and box tests under random stalls.
module tb_frustum_box_cull;
   timeunit 1ns;
   timeprecision 1ps;

   import fbc_pkg::*;

   localparam int          ONE         = 32'h0001_0000;   // 1.0 in Q16.16
   localparam logic [31:0] MIN32       = 32'h8000_0000;
   localparam logic [31:0] MAX32       = 32'h7fff_ffff;
   localparam int          NUM_ITEMS   = 1550;
   localparam int          MAX_GAP     = 10;
   localparam int          HOLD_CYCLES = 150;
   localparam int          SETTLE      = 12;

   typedef enum int {MS_PERSPECTIVE, MS_SMALL, MS_SPARSE, MS_WILD, MS_TWEAK} mat_style_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_push    = 1'b0;
   req_type req_payload = '0;
   logic    req_full;
   logic    rsp_empty;
   logic    rsp_pop     = 1'b0;
   rsp_type rsp_payload;

   frustum_box_cull dut (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_payload(req_payload),
      .req_full   (req_full),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_payload(rsp_payload)
   );

   req_type            pending [$];
   rsp_type            verdicts_due [$];
   logic signed [31:0] view_proj [16] = '{default: '0};
   req_type            next_item;
   int items_queued  = 0;
   int items_sent    = 0;
   int verdicts_seen = 0;
   int n_culled      = 0;
   int n_visible     = 0;
   int n_degenerate  = 0;
   int errors        = 0;
   int matrix_sets   = 0;
   int drains        = 0;
   int send_wait     = 0;
   int take_wait     = 0;
   int gap_now       = 0;
   int hold_left     = 0;
   int holds_done    = 0;

   initial forever #5 clock = ~clock;

   // ---------------- expected behavior ----------------

   function automatic logic signed [127:0] elem(int r, int c);
      return view_proj[r * 4 + c];
   endfunction

   function automatic logic signed [127:0] narrow_coord(logic [31:0] v);
      logic signed [CW-1:0] n;
      n = v[CW-1:0];
      return n;
   endfunction

   function automatic rsp_type judge_box(req_type it);
      logic signed [127:0] coef [6][4];
      logic signed [127:0] lo [3];
      logic signed [127:0] hi [3];
      logic signed [127:0] plane_dist;
      logic    frustum_ok;
      logic    box_ok;
      logic    culled;
      rsp_type v;
      int      p;
      int      k;
      lo[0] = narrow_coord(it.min_x);
      lo[1] = narrow_coord(it.min_y);
      lo[2] = narrow_coord(it.min_z);
      hi[0] = narrow_coord(it.max_x);
      hi[1] = narrow_coord(it.max_y);
      hi[2] = narrow_coord(it.max_z);
      box_ok = 1'b1;
      for (k = 0; k < 3; k++)
         if (lo[k] > hi[k]) box_ok = 1'b0;
      for (k = 0; k < 4; k++) begin
         coef[PL_LEFT][k]   = elem(3, k) + elem(0, k);
         coef[PL_RIGHT][k]  = elem(3, k) - elem(0, k);
         coef[PL_BOTTOM][k] = elem(3, k) + elem(1, k);
         coef[PL_TOP][k]    = elem(3, k) - elem(1, k);
         coef[PL_NEAR][k]   = elem(2, k);
         coef[PL_FAR][k]    = elem(3, k) - elem(2, k);
      end
      frustum_ok = 1'b1;
      culled     = 1'b0;
      for (p = 0; p < NUM_PLANES; p++) begin
         if (coef[p][0] == 0 && coef[p][1] == 0 && coef[p][2] == 0) frustum_ok = 1'b0;
         // offset is Q16.16, products are Q32.32; zero coefficient takes the max corner
         plane_dist = coef[p][3] <<< FRAC_BITS;
         for (k = 0; k < 3; k++)
            plane_dist += coef[p][k] * ((coef[p][k] >= 0) ? hi[k] : lo[k]);
         if (plane_dist < 0) culled = 1'b1;
      end
      v.frustum_ok = frustum_ok;
      v.visible    = !(frustum_ok && box_ok && culled);
      return v;
   endfunction

   task automatic track_item(req_type it);
      if (it.kind == KIND_LOAD)
         view_proj[{it.row, it.col}] = it.matrix_value;
      else
         verdicts_due.push_back(judge_box(it));
   endtask

   task automatic report_mismatch(string what);
      errors++;
      if (errors <= 40) $display("%0t ns, result %0d: %s", $time, verdicts_seen, what);
   endtask

   task automatic check_verdict(rsp_type got);
      rsp_type want;
      if (verdicts_due.size() == 0) begin
         report_mismatch($sformatf("result with nothing outstanding: visible=%b frustum_ok=%b",
                                   got.visible, got.frustum_ok));
         return;
      end
      want = verdicts_due.pop_front();
      verdicts_seen++;
      if (!want.visible) n_culled++;
      else n_visible++;
      if (!want.frustum_ok) n_degenerate++;
      if (got.visible !== want.visible)
         report_mismatch($sformatf("visible %b, want %b", got.visible, want.visible));
      if (got.frustum_ok !== want.frustum_ok)
         report_mismatch($sformatf("frustum_ok %b, want %b", got.frustum_ok, want.frustum_ok));
   endtask

   function automatic int pick_gap(bit calm);
      return calm ? 0 : int'($urandom_range(0, MAX_GAP));
   endfunction

   // ---------------- driver and monitor ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_push  <= 1'b0;
         send_wait <= 0;
      end else begin
         if (req_push && !req_full) begin
            track_item(req_payload);
            items_sent <= items_sent + 1;
         end
         if (!req_push || !req_full) begin
            if (send_wait != 0) begin
               send_wait <= send_wait - 1;
               req_push  <= 1'b0;
            end else if (pending.size() != 0) begin
               next_item = pending.pop_front();
               req_payload <= next_item;
               req_push    <= 1'b1;
               send_wait   <= pick_gap(items_sent % 256 < 64);
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop   <= 1'b0;
         take_wait <= 0;
      end else if (rsp_pop && !rsp_empty) begin
         check_verdict(rsp_payload);
         gap_now = pick_gap(verdicts_seen % 192 < 48);
         take_wait <= (gap_now == 0) ? 0 : gap_now - 1;
         rsp_pop   <= (gap_now == 0) && (hold_left == 0);
      end else if (take_wait != 0) begin
         take_wait <= take_wait - 1;
         rsp_pop   <= 1'b0;
      end else begin
         rsp_pop <= (hold_left == 0);
      end
   end

   // long output stalls so the block backs up and raises full
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         holds_done <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if ((holds_done == 0 && items_sent >= 500) ||
                   (holds_done == 1 && items_sent >= 1200)) begin
         hold_left  <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end
   end

   // ---------------- stimulus ----------------

   function automatic req_type noise_item();
      req_type it;
      it.kind         = 1'($urandom);
      it.row          = 2'($urandom);
      it.col          = 2'($urandom);
      it.matrix_value = $urandom;
      it.min_x        = $urandom;
      it.min_y        = $urandom;
      it.min_z        = $urandom;
      it.max_x        = $urandom;
      it.max_y        = $urandom;
      it.max_z        = $urandom;
      return it;
   endfunction

   function automatic int signed_span(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   task automatic queue_load(int r, int c, logic [31:0] v);
      req_type it;
      it = noise_item();
      it.kind         = KIND_LOAD;
      it.row          = 2'(r);
      it.col          = 2'(c);
      it.matrix_value = v;
      pending.push_back(it);
      items_queued++;
   endtask

   task automatic queue_box(logic [31:0] x0, logic [31:0] y0, logic [31:0] z0,
                            logic [31:0] x1, logic [31:0] y1, logic [31:0] z1);
      req_type it;
      it = noise_item();
      it.kind  = KIND_TEST;
      it.min_x = x0;
      it.min_y = y0;
      it.min_z = z0;
      it.max_x = x1;
      it.max_y = y1;
      it.max_z = z1;
      pending.push_back(it);
      items_queued++;
   endtask

   task automatic load_matrix(mat_style_type style);
      logic [31:0] m [16];
      int order [16];
      int i;
      int j;
      int t;
      for (i = 0; i < 16; i++) begin
         order[i] = i;
         case (style)
            MS_SMALL:  m[i] = ($urandom_range(0, 4) == 0) ? 0 : signed_span(2 * ONE);
            MS_SPARSE: m[i] = ($urandom_range(0, 1) == 0) ? 0 :
                              ($urandom_range(0, 1) == 0) ? ONE : -ONE;
            MS_WILD:   m[i] = $urandom;
            default:   m[i] = 0;
         endcase
      end
      if (style == MS_TWEAK) begin
         t = $urandom_range(1, 3);
         for (i = 0; i < t; i++)
            queue_load($urandom_range(0, 3), $urandom_range(0, 3),
                       ($urandom_range(0, 1) == 0) ? $urandom : signed_span(2 * ONE));
         return;
      end
      if (style == MS_PERSPECTIVE) begin
         // projection with w = -z; optional skew for an off-center frustum
         m[0]  = $urandom_range(ONE / 2, 3 * ONE);
         m[5]  = $urandom_range(ONE / 2, 3 * ONE);
         m[10] = -int'($urandom_range(ONE, 3 * ONE));
         m[11] = -int'($urandom_range(ONE / 8, 2 * ONE));
         m[14] = -ONE;
         if ($urandom_range(0, 2) == 0) begin
            m[2] = signed_span(ONE / 2);
            m[6] = signed_span(ONE / 2);
         end
      end
      for (i = 15; i > 0; i--) begin
         j        = $urandom_range(0, i);
         t        = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      for (i = 0; i < 16; i++)
         queue_load(order[i] / 4, order[i] % 4, m[order[i]]);
      matrix_sets++;
   endtask

   task automatic queue_burst();
      int lo [3];
      int hi [3];
      int n;
      int i;
      int a;
      int c;
      int h;
      int pick;
      n = $urandom_range(4, 30);
      for (i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 7) begin
            queue_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         end else begin
            for (a = 0; a < 3; a++) begin
               c     = signed_span(6 * ONE);
               h     = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 2 * ONE);
               lo[a] = c - h;
               hi[a] = c + h;
            end
            if (pick < 15) begin
               // inverted on one axis
               a     = $urandom_range(0, 2);
               c     = lo[a];
               lo[a] = hi[a];
               hi[a] = (c == lo[a]) ? c - 1 : c;
            end
            queue_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
         end
         if ($urandom_range(0, 19) == 0)
            queue_load($urandom_range(0, 3), $urandom_range(0, 3), signed_span(2 * ONE));
      end
   endtask

   task automatic wait_drained();
      while (pending.size() != 0 || req_push || verdicts_due.size() != 0) @(posedge clock);
      drains++;
   endtask

   initial begin
      mat_style_type style;
      int            pick;

      // all-zero matrix after reset: every normal is zero
      queue_box(MIN32, MIN32, MIN32, MAX32, MAX32, MAX32);
      // identity: planes x+1, -x+1, y+1, -y+1, z, -z+1
      queue_load(0, 0, ONE);
      queue_load(1, 1, ONE);
      queue_load(2, 2, ONE);
      queue_load(3, 3, ONE);
      queue_box(-ONE / 2, -ONE / 2, ONE / 4, ONE / 2, ONE / 2, 3 * ONE / 4);
      queue_box(-ONE, 0, ONE / 2, -ONE, 0, ONE / 2);            // lies on the left plane
      queue_box(-3 * ONE, -ONE, ONE / 4, -2 * ONE, ONE, ONE / 2);
      queue_box(-ONE, -ONE, -2 * ONE, ONE, ONE, -ONE);
      queue_box(-ONE, -ONE, 2 * ONE, ONE, ONE, 3 * ONE);
      queue_box(-2 * ONE, 0, ONE / 2, -3 * ONE, 0, ONE / 2);    // inverted, else culled
      queue_box(MIN32, MIN32, MIN32, MAX32, MAX32, MAX32);
      queue_box(MIN32, MIN32, MIN32, MIN32, MIN32, MIN32);
      // extreme elements, sums past 32 bits
      queue_load(0, 0, MAX32);
      queue_load(3, 0, MAX32);
      queue_load(3, 3, MIN32);
      queue_box(0, 0, ONE / 2, 0, 0, ONE / 2);
      queue_load(3, 3, MAX32);
      queue_box(MIN32, MIN32, MIN32, MAX32, MAX32, MAX32);
      // x column cleared: left and right normals vanish
      queue_load(0, 0, 0);
      queue_load(3, 0, 0);
      queue_box(-3 * ONE, -ONE, ONE / 4, -2 * ONE, ONE, ONE / 2);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait_drained();

      while (items_queued < NUM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)      style = MS_PERSPECTIVE;
         else if (pick < 65) style = MS_SMALL;
         else if (pick < 80) style = MS_SPARSE;
         else if (pick < 90) style = MS_WILD;
         else                style = MS_TWEAK;
         load_matrix(style);
         queue_burst();
         if (drains == 1 && items_queued >= 800) wait_drained();
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      $display("tb_frustum_box_cull: %0d items, %0d boxes (%0d culled, %0d visible, %0d flat)",
               items_sent, verdicts_seen, n_culled, n_visible, n_degenerate);
      $display("tb_frustum_box_cull: %0d full matrix loads, %0d output holds, %0d drain pauses",
               matrix_sets, holds_done, drains);
      if (errors == 0)
         $display("tb_frustum_box_cull: done, clean");
      else
         $display("tb_frustum_box_cull: done, errors");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb_frustum_box_cull: timeout with %0d results outstanding", verdicts_due.size());
      $display("tb_frustum_box_cull: done, errors");
      $finish;
   end

endmodule
